### hdl/pmct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmct_pkg
// Shared types and constants for the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package pmct_pkg;

    typedef enum logic [1:0] {
        MODE_SELFTEST = 2'd0,
        MODE_WAIT_ACK = 2'd1,
        MODE_REPORT   = 2'd2
    } mode_t;

    localparam logic [7:0] BYTE_SELFTEST_OK = 8'hAA;
    localparam logic [7:0] BYTE_ZERO        = 8'h00;
    localparam logic [7:0] BYTE_ACK         = 8'hFA;
    localparam logic [7:0] CMD_ENABLE_REP   = 8'hF4;

    localparam int unsigned STAT_LEFT_BIT = 0;
    localparam int unsigned STAT_XSGN_BIT = 4;
    localparam int unsigned STAT_YSGN_BIT = 5;

    localparam logic [1:0] PKT_LAST = 2'd2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX = 2'd3;

    localparam logic [8:0] X_MIN_RST = 9'd16;
    localparam logic [8:0] X_MAX_RST = 9'd293;
    localparam logic [7:0] Y_MIN_RST = 8'd25;
    localparam logic [7:0] Y_MAX_RST = 8'd222;

    localparam int unsigned DELTA_W = 10;

    typedef struct packed {
        logic                      send;
        logic                      update;
        mode_t                     mode;
        logic                      button;
        logic signed [DELTA_W-1:0] step_x;
        logic signed [DELTA_W-1:0] step_y;
    } entry_t;

endpackage
`default_nettype wire

### hdl/pmct_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmct_front
// Byte window, link mode and packet counter; scales deltas into queue entries.
// ----------------------------------------------------------------------------
module pmct_front #(
    parameter int unsigned SENS_DIV = 5
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_fire,
    input  wire logic [7:0]       in_byte,
    output pmct_pkg::entry_t      entry
);

    localparam int unsigned DIV_SHIFT = 16;
    localparam int unsigned MUL_W     = DIV_SHIFT + 1;
    localparam int unsigned PROD_W    = MUL_W + pmct_pkg::DELTA_W;
    localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'((1 << DIV_SHIFT) / SENS_DIV + 1);
    localparam logic [pmct_pkg::DELTA_W-1:0] DIV_BIAS = pmct_pkg::DELTA_W'(SENS_DIV - 1);

    pmct_pkg::mode_t mode_reg, mode_next;
    logic [7:0]      win1_reg, win1_next;
    logic [7:0]      win2_reg, win2_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            send_c;
    logic            update_c;

    logic signed [pmct_pkg::DELTA_W-1:0] dx_c;
    logic signed [pmct_pkg::DELTA_W-1:0] ndy_c;

    function automatic logic signed [pmct_pkg::DELTA_W-1:0] floor_scale(
        input logic signed [pmct_pkg::DELTA_W-1:0] v
    );
        logic [pmct_pkg::DELTA_W-1:0] mag;
        logic [PROD_W-1:0]            prod;
        logic [pmct_pkg::DELTA_W-1:0] q;
        mag  = v[pmct_pkg::DELTA_W-1] ? (-v + DIV_BIAS) : v;
        prod = PROD_W'(mag) * PROD_W'(DIV_MUL);
        q    = prod[DIV_SHIFT +: pmct_pkg::DELTA_W];
        return v[pmct_pkg::DELTA_W-1] ? -q : q;
    endfunction

    always_comb begin
        mode_next = mode_reg;
        win1_next = win2_reg;
        win2_next = in_byte;
        cnt_next  = cnt_reg;
        send_c    = 1'b0;
        update_c  = 1'b0;
        if (mode_reg == pmct_pkg::MODE_REPORT) begin
            if (cnt_reg == pmct_pkg::PKT_LAST) begin
                cnt_next = 2'd0;
                update_c = 1'b1;
            end else begin
                cnt_next = cnt_reg + 2'd1;
            end
        end else begin
            if (win2_reg == pmct_pkg::BYTE_SELFTEST_OK && in_byte == pmct_pkg::BYTE_ZERO) begin
                mode_next = pmct_pkg::MODE_WAIT_ACK;
                send_c    = 1'b1;
            end
            if ((mode_reg == pmct_pkg::MODE_WAIT_ACK || send_c)
                    && in_byte == pmct_pkg::BYTE_ACK) begin
                mode_next = pmct_pkg::MODE_REPORT;
            end
        end
    end

    always_comb begin
        dx_c  = $signed({{2{win1_reg[pmct_pkg::STAT_XSGN_BIT]}}, win2_reg});
        ndy_c = -$signed({{2{win1_reg[pmct_pkg::STAT_YSGN_BIT]}}, in_byte});
        entry.send   = send_c;
        entry.update = update_c;
        entry.mode   = mode_next;
        entry.button = win1_reg[pmct_pkg::STAT_LEFT_BIT];
        entry.step_x = floor_scale(dx_c);
        entry.step_y = floor_scale(ndy_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= pmct_pkg::MODE_SELFTEST;
            win1_reg <= 8'd0;
            win2_reg <= 8'd0;
            cnt_reg  <= 2'd0;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            win1_reg <= win1_next;
            win2_reg <= win2_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule
`default_nettype wire

### hdl/pmct_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmct_queue
// Two-entry queue between the byte front and the cursor back.
// ----------------------------------------------------------------------------
module pmct_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  pmct_pkg::entry_t      push_entry,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output pmct_pkg::entry_t      head_entry
);

    pmct_pkg::entry_t slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    always_comb begin
        full        = (count_reg == 2'd2);
        head_valid  = (count_reg != 2'd0);
        head_entry  = slot_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

### hdl/pmct_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmct_back
// Box registers, cursor position and clamping, and the output register.
// ----------------------------------------------------------------------------
module pmct_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [pmct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pmct_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               head_valid,
    input  pmct_pkg::entry_t                        head_entry,
    output logic                                    pop,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    out_send,
    output logic [7:0]                              out_send_byte,
    output logic                                    out_update,
    output logic [8:0]                              out_x,
    output logic [7:0]                              out_y,
    output logic                                    out_button,
    output pmct_pkg::mode_t                         out_mode
);

    logic [8:0] x_min_reg, x_max_reg;
    logic [7:0] y_min_reg, y_max_reg;
    logic [8:0] pos_x_reg, pos_x_next;
    logic [7:0] pos_y_reg, pos_y_next;
    logic       btn_reg, btn_next;
    logic       valid_reg;

    logic            send_reg, update_reg;
    pmct_pkg::mode_t mode_reg;

    logic signed [10:0] nx, ny, cx, cy;

    always_comb begin
        pop = head_valid && (!valid_reg || out_ready);
        nx  = $signed({2'b00, pos_x_reg}) + 11'(head_entry.step_x);
        ny  = $signed({3'b000, pos_y_reg}) + 11'(head_entry.step_y);
        cx  = (nx > $signed({2'b00, x_max_reg})) ? $signed({2'b00, x_max_reg}) : nx;
        cx  = (cx < $signed({2'b00, x_min_reg})) ? $signed({2'b00, x_min_reg}) : cx;
        cy  = (ny > $signed({3'b000, y_max_reg})) ? $signed({3'b000, y_max_reg}) : ny;
        cy  = (cy < $signed({3'b000, y_min_reg})) ? $signed({3'b000, y_min_reg}) : cy;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        btn_next   = btn_reg;
        if (head_entry.update) begin
            pos_x_next = cx[8:0];
            pos_y_next = cy[7:0];
            btn_next   = head_entry.button;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg <= pmct_pkg::X_MIN_RST;
            x_max_reg <= pmct_pkg::X_MAX_RST;
            y_min_reg <= pmct_pkg::Y_MIN_RST;
            y_max_reg <= pmct_pkg::Y_MAX_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                pmct_pkg::CFG_X_MIN: x_min_reg <= cfg_wdata;
                pmct_pkg::CFG_X_MAX: x_max_reg <= cfg_wdata;
                pmct_pkg::CFG_Y_MIN: y_min_reg <= cfg_wdata[7:0];
                pmct_pkg::CFG_Y_MAX: y_max_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= pmct_pkg::X_MIN_RST;
            pos_y_reg <= pmct_pkg::Y_MIN_RST;
            btn_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
                btn_reg   <= btn_next;
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            send_reg   <= head_entry.send;
            update_reg <= head_entry.update;
            mode_reg   <= head_entry.mode;
        end
    end

    always_comb begin
        out_valid     = valid_reg;
        out_send      = send_reg;
        out_send_byte = send_reg ? pmct_pkg::CMD_ENABLE_REP : 8'd0;
        out_update    = update_reg;
        out_x         = pos_x_reg;
        out_y         = pos_y_reg;
        out_button    = btn_reg;
        out_mode      = mode_reg;
    end

endmodule
`default_nettype wire

### hdl/ps2_mouse_cursor_tracker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker_top
// Path: an accepted byte is registered as an entry in the queue slot (front into
// the queue), then as its result word in the output register (back). Throughput:
// one byte per cycle while m_tready holds; a stalled output fills the two-entry queue.
// Reset (aresetn low, synchronous): link mode waits for self-test, cursor at
// (16, 25), box registers at their defaults, queue and output emptied.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker_top #(
    parameter int unsigned SENS_DIV = 5
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [pmct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pmct_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // rx_byte[7:0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // send_byte[7:0], cursor_x[16:8], cursor_y[24:17], left_button[25],
    // link_mode[27:26], zero[31:28]
    output logic [31:0]                          m_tdata,
    output logic [1:0]                           m_tuser   // send_valid[0], update_valid[1]
);

    pmct_pkg::entry_t push_entry, head_entry;
    pmct_pkg::mode_t  out_mode;
    logic             full, head_valid, pop, in_fire;
    logic             out_send, out_update, out_button;
    logic [7:0]       out_send_byte, out_y;
    logic [8:0]       out_x;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && !full;

    pmct_front #(
        .SENS_DIV (SENS_DIV)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_byte (s_tdata),
        .entry   (push_entry)
    );

    pmct_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (in_fire),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    pmct_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_send      (out_send),
        .out_send_byte (out_send_byte),
        .out_update    (out_update),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_button    (out_button),
        .out_mode      (out_mode)
    );

    assign m_tdata = {4'd0, out_mode, out_button, out_y, out_x, out_send_byte};
    assign m_tuser = {out_update, out_send};

endmodule
`default_nettype wire
